FILE: design/sab_pkg.sv
// Package for the suffix automaton builder.
// Sequencer state type, result record and fixed payload widths.
// No dependencies.
`default_nettype none

package sab_pkg;

	localparam int SYM_W = 5;
	localparam int OUT_W = 11;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_INIT,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_WALK_LNK,
		ST_LEN_CUR,
		ST_LEN_CMP,
		ST_CP_RD,
		ST_CP_WR,
		ST_CL_LINK,
		ST_CL_FIX,
		ST_RD_RD,
		ST_RD_CHK,
		ST_RD_LNK,
		ST_FIN,
		ST_DONE
	} fsm_t;

	typedef struct packed {
		logic [OUT_W-1:0] new_state;
		logic [OUT_W-1:0] suffix_link;
		logic [OUT_W-1:0] prefix_length;
		logic [OUT_W-1:0] state_count;
		logic             full_res;
	} res_t;

endpackage

`default_nettype wire

FILE: design/sab_ifs.sv
// Handshake channels of the suffix automaton builder.
// Symbol input channel and result output channel; depends on sab_pkg.
`default_nettype none

interface sab_sym_if import sab_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;

	modport source (output valid, output symbol, input ready);
	modport sink (input valid, input symbol, output ready);
endinterface

interface sab_res_if import sab_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] new_state;
	logic [OUT_W-1:0] suffix_link;
	logic [OUT_W-1:0] prefix_length;
	logic [OUT_W-1:0] state_count;
	logic             full_res;

	modport source (output valid, output new_state, output suffix_link,
		output prefix_length, output state_count, output full_res, input ready);
	modport sink (input valid, input new_state, input suffix_link,
		input prefix_length, input state_count, input full_res, output ready);
endinterface

`default_nettype wire

FILE: design/sab_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sab_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 2047
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: design/suffix_automaton_builder_core.sv
// Suffix automaton builder, top level: sequencer over three RAMs
// (transitions, suffix links, lengths). Depends on sab_pkg, sab_ifs, sab_ram.
//
// channel  | dir | fields
// sym_ch   | in  | symbol
// res_ch   | out | new_state, suffix_link, prefix_length, state_count, full_res
//
// One item at a time: a new symbol is taken only in the idle state, once the last is done.
// Per item: clear the new state's transition row, then walk the suffix links, adding an
// edge at each step, and compare lengths when the walk stops at an existing edge; a clone
// copies the target's row and link and sets its length, then redirects edges along the
// suffix links until it meets an edge leading elsewhere or runs out of links. Ignored
// symbols go straight to the result. After reset the root row is cleared; no item is taken meanwhile.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module suffix_automaton_builder_core import sab_pkg::*; #(
	parameter int MAX_LEN  = 1024,
	parameter int ALPHABET = 26
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sab_sym_if.sink    sym_ch,
	sab_res_if.source  res_ch
);

	localparam int NUM_ST = 2 * MAX_LEN - 1;
	localparam int SW     = $clog2(NUM_ST + 1);
	localparam int LW     = $clog2(MAX_LEN + 1);
	localparam int AW     = $clog2(ALPHABET);
	localparam int CD     = NUM_ST * ALPHABET;
	localparam int CAW    = $clog2(CD);
	localparam int STAW   = $clog2(NUM_ST);
	localparam logic [SW-1:0] NULL_ST = SW'(NUM_ST);

	fsm_t fsm_q, fsm_d;

	logic [AW-1:0]  sym_q;
	logic [AW-1:0]  idx_q;
	logic [SW-1:0]  cnt_q, last_q, ns_q, cur_q, nxt_q, cl_q, lnk_q;
	logic [LW-1:0]  taken_q, lencur_q;
	res_t           res_q;
	logic           out_valid_q;

	logic           c_we;
	logic [CAW-1:0] c_waddr, c_raddr;
	logic [SW-1:0]  c_wdata, c_rdata;
	logic [SW-1:0]  c_wst, c_rst;
	logic [AW-1:0]  c_widx, c_ridx;
	logic           k_we;
	logic [STAW-1:0] k_waddr, k_raddr;
	logic [SW-1:0]  k_wdata, k_rdata;
	logic           l_we;
	logic [STAW-1:0] l_waddr, l_raddr;
	logic [LW-1:0]  l_wdata, l_rdata;

	logic           accept, sym_ok, is_full, out_load, idx_last;

	assign sym_ch.ready = (fsm_q == ST_IDLE);
	assign accept       = sym_ch.valid && sym_ch.ready;
	assign is_full      = (taken_q == LW'(MAX_LEN));
	assign sym_ok       = (32'(sym_ch.symbol) < 32'(ALPHABET)) && !is_full;
	assign idx_last     = (idx_q == AW'(ALPHABET - 1));
	assign out_load     = (fsm_q == ST_DONE) && (!out_valid_q || res_ch.ready);

	assign c_waddr = CAW'(CAW'(c_wst) * CAW'(ALPHABET)) + CAW'(c_widx);
	assign c_raddr = CAW'(CAW'(c_rst) * CAW'(ALPHABET)) + CAW'(c_ridx);

	always_comb begin
		fsm_d   = fsm_q;
		c_we    = 1'b0;
		c_wst   = cur_q;
		c_widx  = sym_q;
		c_wdata = NULL_ST;
		c_rst   = cur_q;
		c_ridx  = sym_q;
		k_we    = 1'b0;
		k_waddr = STAW'(ns_q);
		k_wdata = lnk_q;
		k_raddr = STAW'(cur_q);
		l_we    = 1'b0;
		l_waddr = STAW'(ns_q);
		l_wdata = LW'(taken_q + LW'(1));
		l_raddr = STAW'(cur_q);
		unique case (fsm_q)
			ST_CLR: begin
				c_we   = 1'b1;
				c_wst  = '0;
				c_widx = idx_q;
				k_we    = (idx_q == '0);
				k_waddr = '0;
				k_wdata = NULL_ST;
				l_we    = (idx_q == '0);
				l_waddr = '0;
				l_wdata = '0;
				if (idx_last) fsm_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (sym_ok) begin
						l_we    = 1'b1;
						l_waddr = STAW'(cnt_q);
						fsm_d   = ST_INIT;
					end else begin
						fsm_d = ST_DONE;
					end
				end
			end
			ST_INIT: begin
				c_we   = 1'b1;
				c_wst  = ns_q;
				c_widx = idx_q;
				if (idx_last) fsm_d = ST_WALK_RD;
			end
			ST_WALK_RD: fsm_d = ST_WALK_CHK;
			ST_WALK_CHK: begin
				if (c_rdata == NULL_ST) begin
					c_we    = 1'b1;
					c_wdata = ns_q;
					fsm_d   = ST_WALK_LNK;
				end else begin
					fsm_d = ST_LEN_CUR;
				end
			end
			ST_WALK_LNK: fsm_d = (k_rdata == NULL_ST) ? ST_FIN : ST_WALK_RD;
			ST_LEN_CUR: begin
				l_raddr = STAW'(nxt_q);
				fsm_d   = ST_LEN_CMP;
			end
			ST_LEN_CMP: begin
				fsm_d = (LW'(lencur_q + LW'(1)) == l_rdata) ? ST_FIN : ST_CP_RD;
			end
			ST_CP_RD: begin
				c_rst  = nxt_q;
				c_ridx = idx_q;
				fsm_d  = ST_CP_WR;
			end
			ST_CP_WR: begin
				c_we    = 1'b1;
				c_wst   = cl_q;
				c_widx  = idx_q;
				c_wdata = c_rdata;
				k_raddr = STAW'(nxt_q);
				fsm_d   = idx_last ? ST_CL_LINK : ST_CP_RD;
			end
			ST_CL_LINK: begin
				k_we    = 1'b1;
				k_waddr = STAW'(cl_q);
				k_wdata = k_rdata;
				l_we    = 1'b1;
				l_waddr = STAW'(cl_q);
				l_wdata = LW'(lencur_q + LW'(1));
				fsm_d   = ST_CL_FIX;
			end
			ST_CL_FIX: begin
				k_we    = 1'b1;
				k_waddr = STAW'(nxt_q);
				k_wdata = cl_q;
				fsm_d   = ST_RD_RD;
			end
			ST_RD_RD: fsm_d = ST_RD_CHK;
			ST_RD_CHK: begin
				if (c_rdata == nxt_q) begin
					c_we    = 1'b1;
					c_wdata = cl_q;
					fsm_d   = ST_RD_LNK;
				end else begin
					fsm_d = ST_FIN;
				end
			end
			ST_RD_LNK: fsm_d = (k_rdata == NULL_ST) ? ST_FIN : ST_RD_RD;
			ST_FIN: begin
				k_we  = 1'b1;
				fsm_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) fsm_d = ST_IDLE;
			end
			default: fsm_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= ST_CLR;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= SW'(1);
			last_q      <= '0;
			taken_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (fsm_q)
				ST_CLR, ST_INIT, ST_CP_WR: idx_q <= idx_last ? '0 : AW'(idx_q + AW'(1));
				ST_IDLE: begin
					idx_q <= '0;
					if (accept && sym_ok) cnt_q <= SW'(cnt_q + SW'(1));
				end
				ST_LEN_CMP: begin
					idx_q <= '0;
					if (LW'(lencur_q + LW'(1)) != l_rdata) cnt_q <= SW'(cnt_q + SW'(1));
				end
				ST_FIN: begin
					last_q  <= ns_q;
					taken_q <= LW'(taken_q + LW'(1));
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (fsm_q)
			ST_IDLE: begin
				sym_q <= AW'(sym_ch.symbol);
				ns_q  <= cnt_q;
				cur_q <= last_q;
				res_q <= '{new_state: '0, suffix_link: '0,
					prefix_length: OUT_W'(taken_q), state_count: OUT_W'(cnt_q),
					full_res: is_full};
			end
			ST_WALK_CHK: nxt_q <= c_rdata;
			ST_WALK_LNK: begin
				cur_q <= k_rdata;
				lnk_q <= '0;
			end
			ST_LEN_CUR: lencur_q <= l_rdata;
			ST_LEN_CMP: begin
				cl_q  <= cnt_q;
				lnk_q <= nxt_q;
			end
			ST_CL_FIX: lnk_q <= cl_q;
			ST_RD_LNK: cur_q <= k_rdata;
			ST_FIN: begin
				res_q <= '{new_state: OUT_W'(ns_q), suffix_link: OUT_W'(lnk_q),
					prefix_length: OUT_W'(taken_q + LW'(1)), state_count: OUT_W'(cnt_q),
					full_res: 1'b0};
			end
			default: res_q <= res_q;
		endcase
	end

	logic [OUT_W*4:0] out_q;
	always_ff @(posedge clk) begin
		if (out_load) out_q <= res_q;
	end

	assign res_ch.valid         = out_valid_q;
	assign res_ch.new_state     = out_q[OUT_W*4 -: OUT_W];
	assign res_ch.suffix_link   = out_q[OUT_W*3 -: OUT_W];
	assign res_ch.prefix_length = out_q[OUT_W*2 -: OUT_W];
	assign res_ch.state_count   = out_q[OUT_W -: OUT_W];
	assign res_ch.full_res      = out_q[0];

	sab_ram #(.WIDTH(SW), .DEPTH(CD)) u_child (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	sab_ram #(.WIDTH(SW), .DEPTH(NUM_ST)) u_link (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	sab_ram #(.WIDTH(LW), .DEPTH(NUM_ST)) u_len (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= NUM_ST)
		else $error("state count beyond capacity");

	a_taken_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(taken_q) <= MAX_LEN)
		else $error("symbol count beyond capacity");

	a_new_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sym_ok) |=> (cnt_q == SW'($past(cnt_q) + SW'(1))))
		else $error("new state not allocated");

	a_no_self_link: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == ST_FIN) |-> (lnk_q != ns_q))
		else $error("new state links to itself");

	a_taken_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == ST_FIN) |=> (taken_q == LW'($past(taken_q) + LW'(1))))
		else $error("length not advanced");

endmodule

`default_nettype wire

FILE: sim/suffix_automaton_builder_core_test.sv
// Testbench for suffix_automaton_builder_core: symbols go in, one result item comes out each.
// Holds its own suffix automaton to predict every result; depends on sab_pkg and sab_ifs.
`timescale 1ns / 100ps

module suffix_automaton_builder_core_test;
	import sab_pkg::*;

	localparam int MAX_LEN  = 1024;
	localparam int ALPHABET = 26;
	localparam int NSTATES  = 2 * MAX_LEN - 1;
	localparam int NIL      = NSTATES;
	localparam int DRAIN    = -1;

	logic clk;
	logic arst_n;

	sab_sym_if sym_ch ();
	sab_res_if res_ch ();

	suffix_automaton_builder_core #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sym_ch(sym_ch),
		.res_ch(res_ch)
	);

	// automaton mirror
	logic [OUT_W-1:0] edges [0:NSTATES*ALPHABET-1];
	logic [OUT_W-1:0] links [0:NSTATES-1];
	logic [OUT_W-1:0] lens [0:NSTATES-1];
	int tail_state;
	int num_states;

	int   symbol_queue[$];
	res_t expected_results[$];
	int   mismatches;
	bit   failed;
	bit   quiet;
	bit   draining;
	int   send_gap;
	int   stall_gap;
	int   sent_count = 0;
	int   taken_count = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int alloc_state();
		int s;
		s = num_states;
		for (int a = 0; a < ALPHABET; a++)
			edges[s*ALPHABET+a] = OUT_W'(NIL);
		links[s] = OUT_W'(NIL);
		lens[s] = '0;
		num_states++;
		return s;
	endfunction

	function automatic res_t extend_automaton(logic [SYM_W-1:0] sym);
		res_t r;
		int taken, ns, cur, nxt, lnk, cl;
		taken = lens[tail_state];
		if (taken >= MAX_LEN || sym >= ALPHABET) begin
			r.new_state = '0;
			r.suffix_link = '0;
			r.prefix_length = OUT_W'(taken);
			r.state_count = OUT_W'(num_states);
			r.full_res = (taken >= MAX_LEN);
			return r;
		end
		ns = alloc_state();
		lens[ns] = OUT_W'(taken + 1);
		cur = tail_state;
		while (cur != NIL && edges[cur*ALPHABET+sym] == NIL) begin
			edges[cur*ALPHABET+sym] = OUT_W'(ns);
			cur = links[cur];
		end
		if (cur == NIL) begin
			lnk = 0;
		end else begin
			nxt = edges[cur*ALPHABET+sym];
			if (lens[cur] + 1 == lens[nxt]) begin
				lnk = nxt;
			end else begin
				cl = alloc_state();
				for (int a = 0; a < ALPHABET; a++)
					edges[cl*ALPHABET+a] = edges[nxt*ALPHABET+a];
				links[cl] = links[nxt];
				lens[cl] = OUT_W'(lens[cur] + 1);
				links[nxt] = OUT_W'(cl);
				while (cur != NIL && edges[cur*ALPHABET+sym] == nxt) begin
					edges[cur*ALPHABET+sym] = OUT_W'(cl);
					cur = links[cur];
				end
				lnk = cl;
			end
		end
		links[ns] = OUT_W'(lnk);
		tail_state = ns;
		r.new_state = OUT_W'(ns);
		r.suffix_link = OUT_W'(lnk);
		r.prefix_length = lens[ns];
		r.state_count = OUT_W'(num_states);
		r.full_res = 1'b0;
		return r;
	endfunction

	// sender; a driven item is held until the monitor has seen it taken
	always @(negedge clk) begin
		if (arst_n && (!sym_ch.valid || taken_count == sent_count)) begin
			if (draining) begin
				if (expected_results.size() == 0)
					draining <= 1'b0;
				sym_ch.valid <= 1'b0;
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				sym_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(1, 18) - 1;
				sym_ch.valid <= 1'b0;
			end else if (symbol_queue.size() > 0) begin
				if (symbol_queue[0] == DRAIN) begin
					void'(symbol_queue.pop_front());
					draining <= 1'b1;
					sym_ch.valid <= 1'b0;
				end else begin
					sym_ch.symbol <= SYM_W'(symbol_queue.pop_front());
					sym_ch.valid <= 1'b1;
					sent_count <= sent_count + 1;
				end
			end else begin
				sym_ch.valid <= 1'b0;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (stall_gap > 0) begin
			stall_gap <= stall_gap - 1;
			res_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_gap <= $urandom_range(1, 18) - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t got, want;
		if (res_ch.valid && res_ch.ready) begin
			got.new_state = res_ch.new_state;
			got.suffix_link = res_ch.suffix_link;
			got.prefix_length = res_ch.prefix_length;
			got.state_count = res_ch.state_count;
			got.full_res = res_ch.full_res;
			if (expected_results.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
		if (sym_ch.valid && sym_ch.ready) begin
			taken_count++;
			expected_results.push_back(extend_automaton(sym_ch.symbol));
		end
	end

	initial begin
		#20_000_000;
		$display("suffix_automaton_builder_core_test NOT OK");
		$finish;
	end

	initial begin
		int pick;
		for (int i = 0; i < NSTATES*ALPHABET; i++)
			edges[i] = OUT_W'(NIL);
		links[0] = OUT_W'(NIL);
		lens[0] = '0;
		tail_state = 0;
		num_states = 1;
		mismatches = 0;
		failed = 1'b0;
		quiet = 1'b0;
		draining = 1'b0;
		send_gap = 0;
		stall_gap = 0;
		sym_ch.valid = 1'b0;
		sym_ch.symbol = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;

		// edges of the alphabet, out-of-range codes, repeats and clone-forcing words
		symbol_queue = {31, 0, 25, 26, 0, 0, 0, 1, 0, 1, 30, 1, 2, 0, 1, 2, 25, 25, 0, 25};
		symbol_queue.push_back(DRAIN);
		for (int i = 0; i < 727; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 11)
				symbol_queue.push_back($urandom_range(0, 2));
			else if (pick < 18)
				symbol_queue.push_back($urandom_range(0, ALPHABET - 1));
			else
				symbol_queue.push_back($urandom_range(ALPHABET, 31));
			if (i == 400)
				symbol_queue.push_back(DRAIN);
		end
		symbol_queue.push_back(0);
		symbol_queue.push_back(31);
		symbol_queue.push_back(25);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (symbol_queue.size() < 120);
		quiet = 1'b1;
		wait (symbol_queue.size() == 0 && !sym_ch.valid && !draining);
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (!failed && expected_results.size() == 0) begin
			$display("suffix_automaton_builder_core_test OK");
		end else begin
			$display("suffix_automaton_builder_core_test NOT OK");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/sab_pkg.sv
design/sab_ifs.sv
design/sab_ram.sv
design/suffix_automaton_builder_core.sv
sim/suffix_automaton_builder_core_test.sv
